// ===== rtl/core/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants of the integer to ASCII converter: format codes,
// sequencer states, character tables and the control bundle of the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

   // format selector codes as carried on the request tuser
   typedef enum logic [2:0] {
      FMT_UDEC = 3'd0,
      FMT_SDEC = 3'd1,
      FMT_HEXL = 3'd2,
      FMT_HEXU = 3'd3,
      FMT_BIN  = 3'd4
   } fmt_type;

   // top level sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_LOAD,
      ST_EMIT
   } state_type;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [7:0] LOWER_DIGITS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };

   localparam logic [7:0] UPPER_DIGITS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   // control from the sequencer to the emitter
   typedef struct packed {
      logic    load;
      logic    neg;
      fmt_type fmt;
   } emit_ctrl_type;

   // status from the emitter to the sequencer
   typedef struct packed {
      logic busy;
   } emit_status_type;

   // ascii glyph of one digit
   function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
      digit_char = upper ? UPPER_DIGITS[digit] : LOWER_DIGITS[digit];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/integer_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Integer to ASCII text converter for unsigned and signed decimal, lower and
// upper case hex and binary, one character per result transaction.
// ----------------------------------------------------------------------------
// One request transaction carries a value and a format; the block answers
// with its text, most significant character first, one character per
// transaction, tlast on the final one. Leading zeros are dropped and zero
// gives a single '0'; signed decimal puts '-' before the magnitude. Only the
// low VALUE_WIDTH bits of the value are used, and format codes above binary
// mean unsigned decimal. The block takes one value at a time. Decimal runs
// the binary to BCD unit, which shifts one operand bit per cycle, before
// the first character. Every digit position, leading zeros included, then
// takes a step of the digit shifter (DEC_DIGITS, or VALUE_WIDTH / 4 rounded
// up for hex, or VALUE_WIDTH for binary), after a step for a sign, and the
// sequencer then returns to idle. The shifter stalls while a character
// waits in the output register and rsp_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix #(
   parameter int VALUE_WIDTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] value
   input  wire logic [2:0]  req_tuser,   // [2:0] req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] character
   output logic             rsp_tlast    // last
);

   localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int DW         = 4 * DEC_DIGITS;

   itoa_pkg::state_type       state_ff, state_in;
   itoa_pkg::fmt_type         fmt_c;
   itoa_pkg::fmt_type         fmt_ff;
   itoa_pkg::emit_ctrl_type   emit_ctrl;
   itoa_pkg::emit_status_type emit_status;

   logic [VALUE_WIDTH-1:0] val_c;
   logic [VALUE_WIDTH-1:0] mag_c;
   logic [VALUE_WIDTH-1:0] mag_ff;
   logic                   neg_c;
   logic                   neg_ff;
   logic                   dec_c;
   logic                   accept_c;
   logic                   dab_start;
   logic                   dab_busy;
   logic [DW-1:0]          dab_bcd;

   // format decode, codes without meaning fall back to unsigned decimal
   always_comb begin
      case (itoa_pkg::fmt_type'(req_tuser))
         itoa_pkg::FMT_SDEC: fmt_c = itoa_pkg::FMT_SDEC;
         itoa_pkg::FMT_HEXL: fmt_c = itoa_pkg::FMT_HEXL;
         itoa_pkg::FMT_HEXU: fmt_c = itoa_pkg::FMT_HEXU;
         itoa_pkg::FMT_BIN:  fmt_c = itoa_pkg::FMT_BIN;
         default:            fmt_c = itoa_pkg::FMT_UDEC;
      endcase
   end

   // sign and magnitude of the operand
   assign val_c    = req_tdata[VALUE_WIDTH-1:0];
   assign neg_c    = (fmt_c == itoa_pkg::FMT_SDEC) && val_c[VALUE_WIDTH-1];
   assign mag_c    = neg_c ? (~val_c + VALUE_WIDTH'(1)) : val_c;
   assign dec_c    = (fmt_c == itoa_pkg::FMT_UDEC) || (fmt_c == itoa_pkg::FMT_SDEC);
   assign accept_c = req_tvalid && req_tready;

   // sequencer next state and outputs
   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      dab_start      = 1'b0;
      emit_ctrl.load = 1'b0;
      emit_ctrl.neg  = neg_ff;
      emit_ctrl.fmt  = fmt_ff;
      case (state_ff)
         itoa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dab_start = dec_c;
               state_in  = dec_c ? itoa_pkg::ST_CONV : itoa_pkg::ST_LOAD;
            end
         end
         itoa_pkg::ST_CONV: begin
            if (!dab_busy) begin
               state_in = itoa_pkg::ST_LOAD;
            end
         end
         itoa_pkg::ST_LOAD: begin
            emit_ctrl.load = 1'b1;
            state_in       = itoa_pkg::ST_EMIT;
         end
         itoa_pkg::ST_EMIT: begin
            if (!emit_status.busy) begin
               state_in = itoa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itoa_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itoa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // captured request transaction
   always_ff @(posedge clock) begin
      if (accept_c) begin
         mag_ff <= mag_c;
         neg_ff <= neg_c;
         fmt_ff <= fmt_c;
      end
   end

   itoa_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DEC_DIGITS  (DEC_DIGITS)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .start (dab_start),
      .value (mag_c),
      .busy  (dab_busy),
      .bcd   (dab_bcd)
   );

   itoa_emit #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DEC_DIGITS  (DEC_DIGITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (emit_ctrl),
      .mag        (mag_ff),
      .bcd        (dab_bcd),
      .status     (emit_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/core/itoa_dabble.sv =====
// ----------------------------------------------------------------------------
// itoa_dabble
// Binary to BCD converter: one shift-and-add-3 step per cycle over the
// operand bits, giving all decimal digits once every operand bit is shifted in.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_dabble #(
   parameter int VALUE_WIDTH = 64,
   parameter int DEC_DIGITS  = 20
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [VALUE_WIDTH-1:0]    value,
   output logic                           busy,
   output logic [4*DEC_DIGITS-1:0]        bcd
);

   localparam int DW = 4 * DEC_DIGITS;
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [DW-1:0]          bcd_ff, bcd_in;
   logic [DW-1:0]          adj_c;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj_c[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj_c[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // load on start, else one shift per cycle while busy
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         bin_in  = value;
         bcd_in  = '0;
         cnt_in  = CW'(VALUE_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adj_c[DW-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign bcd  = bcd_ff;

endmodule

`default_nettype wire

// ===== rtl/core/itoa_emit.sv =====
// ----------------------------------------------------------------------------
// itoa_emit
// Character emitter: holds the digits left aligned, shifts one digit out per
// cycle while the output register is free or taken, drops leading zeros,
// prefixes the sign and drives the result stream through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_emit #(
   parameter int VALUE_WIDTH = 64,
   parameter int DEC_DIGITS  = 20
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire itoa_pkg::emit_ctrl_type      ctrl,
   input  wire logic [VALUE_WIDTH-1:0]       mag,
   input  wire logic [4*DEC_DIGITS-1:0]      bcd,
   output itoa_pkg::emit_status_type         status,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] character
   output logic                              rsp_tlast
);

   localparam int DW   = 4 * DEC_DIGITS;
   localparam int HEXW = (VALUE_WIDTH + 3) / 4;
   localparam int CW   = $clog2(VALUE_WIDTH + 1);

   logic [DW-1:0] dig_ff, dig_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          lead_ff, lead_in;
   logic          sign_ff, sign_in;
   logic          bin_ff, bin_in;
   logic          upper_ff, upper_in;
   logic          active_ff, active_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]    rsp_tdata_ff;
   logic          rsp_tlast_ff;

   logic [DW-1:0] hex_al_c;
   logic [DW-1:0] bin_al_c;
   logic          step_c;
   logic [3:0]    digit_c;
   logic          last_digit_c;
   logic          skip_c;
   logic          emit_c;
   logic [7:0]    char_c;
   logic          last_c;

   // operand left aligned for hex and binary digits
   assign hex_al_c = DW'(mag) << (DW - 4 * HEXW);
   assign bin_al_c = DW'(mag) << (DW - VALUE_WIDTH);

   // current digit and whether it goes out
   assign step_c       = active_ff && (!rsp_tvalid_ff || rsp_tready);
   assign digit_c      = bin_ff ? {3'b000, dig_ff[DW-1]} : dig_ff[DW-1 -: 4];
   assign last_digit_c = (cnt_ff == CW'(1));
   assign skip_c       = !sign_ff && lead_ff && (digit_c == 4'd0) && !last_digit_c;
   assign emit_c       = step_c && !skip_c;
   assign char_c       = sign_ff ? itoa_pkg::CHAR_MINUS
                                 : itoa_pkg::digit_char(digit_c, upper_ff);
   assign last_c       = !sign_ff && last_digit_c;

   // digit register, count and leading zero tracking
   always_comb begin
      dig_in    = dig_ff;
      cnt_in    = cnt_ff;
      lead_in   = lead_ff;
      sign_in   = sign_ff;
      bin_in    = bin_ff;
      upper_in  = upper_ff;
      active_in = active_ff;
      if (ctrl.load) begin
         lead_in   = 1'b1;
         sign_in   = ctrl.neg;
         active_in = 1'b1;
         bin_in    = 1'b0;
         upper_in  = 1'b0;
         case (ctrl.fmt)
            itoa_pkg::FMT_HEXL: begin
               dig_in = hex_al_c;
               cnt_in = CW'(HEXW);
            end
            itoa_pkg::FMT_HEXU: begin
               dig_in   = hex_al_c;
               cnt_in   = CW'(HEXW);
               upper_in = 1'b1;
            end
            itoa_pkg::FMT_BIN: begin
               dig_in = bin_al_c;
               cnt_in = CW'(VALUE_WIDTH);
               bin_in = 1'b1;
            end
            default: begin
               dig_in = bcd;
               cnt_in = CW'(DEC_DIGITS);
            end
         endcase
      end else if (step_c) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else begin
            dig_in  = bin_ff ? (dig_ff << 1) : (dig_ff << 4);
            cnt_in  = cnt_ff - CW'(1);
            lead_in = skip_c;
            if (last_digit_c) begin
               active_in = 1'b0;
            end
         end
      end
   end

   // output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (emit_c) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dig_ff   <= dig_in;
      cnt_ff   <= cnt_in;
      lead_ff  <= lead_in;
      sign_ff  <= sign_in;
      bin_ff   <= bin_in;
      upper_ff <= upper_in;
      if (emit_c) begin
         rsp_tdata_ff <= char_c;
         rsp_tlast_ff <= last_c;
      end
   end

   assign status.busy = active_ff;
   assign rsp_tvalid  = rsp_tvalid_ff;
   assign rsp_tdata   = rsp_tdata_ff;
   assign rsp_tlast   = rsp_tlast_ff;

`ifndef SYNTHESIS
   // a new value is never loaded over one still being emitted
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> !active_ff)
      else $error("emitter loaded while active");

   // the final character ends the emission
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit_c && last_c) |=> !active_ff)
      else $error("emitter still active after final character");

   // the sign is never the final character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && (rsp_tdata_ff == itoa_pkg::CHAR_MINUS)) |-> !rsp_tlast_ff)
      else $error("sign marked as last character");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the integer to ASCII converter. Every accepted value
// is turned into its expected text by a local predictor. Each result
// transaction is checked against the oldest expected character and its tlast.
// Directed corner values come first, then random values under random gaps on
// both streams, then a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 100;

   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [7:0] ASCII_MINUS   = 8'h2D;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;

   // one character of converted text as it should leave the block
   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [63:0] value
   logic [2:0]  req_tuser = '0;   // [2:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] character
   logic        rsp_tlast;

   text_char_type expected_text [$];
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_request = 0;
   int stall_left = 0;

   integer_to_ascii_radix uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit reached with %0d characters outstanding",
                  $time, expected_text.size());
         $display("simulation failed");
         $finish;
      end
   end

   // receiver ready, random idling or a long counted hold-off
   always @(posedge clock) begin
      if (stall_request > 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_text.size() == 0) begin
            $display("%0t: unexpected result transaction, got character %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_tdata !== want.character) begin
               $display("%0t: character mismatch, expected %h got %h",
                        $time, want.character, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: tlast mismatch, expected %b got %b",
                        $time, want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // expected text of one value, queued character by character
   function automatic void predict_text(input logic [63:0] value, input logic [2:0] code);
      itoa_pkg::fmt_type fmt;
      logic [63:0]   mag;
      logic [7:0]    digits [$];
      logic [7:0]    ch;
      logic [3:0]    nibble;
      text_char_type item;
      fmt = (code > itoa_pkg::FMT_BIN) ? itoa_pkg::FMT_UDEC : itoa_pkg::fmt_type'(code);
      mag = value;
      // negative signed values: sign then two's complement magnitude
      if (fmt == itoa_pkg::FMT_SDEC && value[63]) begin
         item.character = ASCII_MINUS;
         item.last = 1'b0;
         expected_text.push_back(item);
         mag = -value;
      end
      do begin
         case (fmt)
            itoa_pkg::FMT_HEXL, itoa_pkg::FMT_HEXU: begin
               nibble = mag[3:0];
               if (nibble < 4'd10)
                  ch = ASCII_ZERO + 8'(nibble);
               else if (fmt == itoa_pkg::FMT_HEXU)
                  ch = ASCII_UPPER_A + 8'(nibble) - 8'd10;
               else
                  ch = ASCII_LOWER_A + 8'(nibble) - 8'd10;
               mag = mag >> 4;
            end
            itoa_pkg::FMT_BIN: begin
               ch = ASCII_ZERO + 8'(mag[0]);
               mag = mag >> 1;
            end
            default: begin
               ch = ASCII_ZERO + 8'(mag % 64'd10);
               mag = mag / 64'd10;
            end
         endcase
         digits.push_front(ch);
      end while (mag != 0);
      foreach (digits[k]) begin
         item.character = digits[k];
         item.last = (k == digits.size() - 1);
         expected_text.push_back(item);
      end
   endfunction

   // offer one value, returns at the edge where it is taken
   task automatic send_value(input logic [63:0] value, input logic [2:0] code);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tuser <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_text(value, code);
   endtask

   // stop offering and wait for every outstanding character
   task automatic wait_text_drained();
      req_tvalid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(3))
         0: random_value = v;
         1: random_value = 64'($urandom_range(1000));
         2: random_value = v >> $urandom_range(63);
         default: begin
            // near the signed and unsigned extremes
            if ($urandom_range(1))
               random_value = 64'h8000_0000_0000_0000 + 64'($urandom_range(20));
            else
               random_value = ~64'($urandom_range(20));
         end
      endcase
   endfunction

   function automatic logic [2:0] random_code();
      if ($urandom_range(15) == 0)
         random_code = 3'($urandom_range(7, 5));
      else
         random_code = 3'($urandom_range(4));
   endfunction

   // corner values in every format
   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // zero in every selector code, meaningless ones included
      for (int c = 0; c < 8; c++)
         send_value(64'd0, 3'(c));
      // all ones
      send_value(64'hFFFF_FFFF_FFFF_FFFF, itoa_pkg::FMT_UDEC);
      send_value(64'hFFFF_FFFF_FFFF_FFFF, itoa_pkg::FMT_SDEC);
      send_value(64'hFFFF_FFFF_FFFF_FFFF, itoa_pkg::FMT_HEXL);
      send_value(64'hFFFF_FFFF_FFFF_FFFF, itoa_pkg::FMT_HEXU);
      send_value(64'hFFFF_FFFF_FFFF_FFFF, itoa_pkg::FMT_BIN);
      // most negative signed value and largest positive one
      send_value(64'h8000_0000_0000_0000, itoa_pkg::FMT_SDEC);
      send_value(64'h8000_0000_0000_0000, itoa_pkg::FMT_UDEC);
      send_value(64'h7FFF_FFFF_FFFF_FFFF, itoa_pkg::FMT_SDEC);
      // every hex letter
      send_value(64'h0123_4567_89AB_CDEF, itoa_pkg::FMT_HEXL);
      send_value(64'h0123_4567_89AB_CDEF, itoa_pkg::FMT_HEXU);
      // codes without meaning fall back to unsigned decimal
      for (int c = 5; c < 8; c++)
         send_value(64'd1234567890, 3'(c));
      send_value(64'd10000000000000000000, itoa_pkg::FMT_UDEC);
      send_value(64'd9, itoa_pkg::FMT_SDEC);
      send_value(64'd1, itoa_pkg::FMT_BIN);
      wait_text_drained();
   endtask

   // random values under the given idling on both streams
   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count)
         send_value(random_value(), random_code());
      wait_text_drained();
   endtask

   // receiver holds off while the sender keeps offering, block must stall
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_request = 300;
      repeat (8)
         send_value(random_value(), random_code());
      wait_text_drained();
      // back to back after a full pause
      repeat (4)
         send_value(random_value(), itoa_pkg::FMT_BIN);
      wait_text_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(95, 12, 47);
      test_random(95, 47, 12);
      test_random(95, 0, 0);
      test_backpressure();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/itoa_pkg.sv
rtl/core/itoa_dabble.sv
rtl/core/itoa_emit.sv
rtl/core/integer_to_ascii_radix.sv
dv/testbench.sv
